[hdl/nva_pkg.sv]
// ----------------------------------------------------------------------------
// nva_pkg
// Types, codes and the note frequency table shared by the tone effect engine.
// ----------------------------------------------------------------------------
package nva_pkg;

   localparam int NOTE_COUNT_DEFAULT = 72;
   localparam int TABLE_LAST         = 71;

   // item kinds
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_ROW     = 2'd1;
   localparam logic [1:0] OP_SILENCE = 2'd2;

   // effect modes
   localparam logic [1:0] MODE_NONE     = 2'd0;
   localparam logic [1:0] MODE_VIB_UP   = 2'd1;
   localparam logic [1:0] MODE_VIB_DOWN = 2'd2;
   localparam logic [1:0] MODE_ARP      = 2'd3;

   // row command kinds (upper nibble of the command)
   localparam logic [3:0] KIND_VIBRATO  = 4'hA;
   localparam logic [3:0] KIND_ARPEGGIO = 4'hB;
   localparam logic [3:0] KIND_END      = 4'hC;

   localparam logic [7:0] TRIGGER_BIT = 8'h80;

   typedef struct packed {
      logic [1:0]  op;
      logic [6:0]  row_note;
      logic [15:0] row_command;
      logic        is_noise;
      logic        channel_owner;
   } nva_req_type;

   typedef struct packed {
      logic       freq_write;
      logic [7:0] freq_low;
      logic [7:0] freq_high;
      logic       noise_trigger;
      logic       end_phrase;
   } nva_rsp_type;

   function automatic logic [15:0] note_freq(input logic [6:0] idx);
      logic [15:0] f;
      case (idx)
         7'd0:  f = 16'h002C;  7'd1:  f = 16'h009D;  7'd2:  f = 16'h0107;
         7'd3:  f = 16'h016B;  7'd4:  f = 16'h01C9;  7'd5:  f = 16'h0223;
         7'd6:  f = 16'h0277;  7'd7:  f = 16'h02C7;  7'd8:  f = 16'h0312;
         7'd9:  f = 16'h0358;  7'd10: f = 16'h039B;  7'd11: f = 16'h03DA;
         7'd12: f = 16'h0416;  7'd13: f = 16'h044E;  7'd14: f = 16'h0483;
         7'd15: f = 16'h04B5;  7'd16: f = 16'h04E5;  7'd17: f = 16'h0511;
         7'd18: f = 16'h053B;  7'd19: f = 16'h0563;  7'd20: f = 16'h0589;
         7'd21: f = 16'h05AC;  7'd22: f = 16'h05CE;  7'd23: f = 16'h05ED;
         7'd24: f = 16'h060B;  7'd25: f = 16'h0627;  7'd26: f = 16'h0642;
         7'd27: f = 16'h065B;  7'd28: f = 16'h0672;  7'd29: f = 16'h0689;
         7'd30: f = 16'h069E;  7'd31: f = 16'h06B2;  7'd32: f = 16'h06C4;
         7'd33: f = 16'h06D6;  7'd34: f = 16'h06E7;  7'd35: f = 16'h06F7;
         7'd36: f = 16'h0706;  7'd37: f = 16'h0714;  7'd38: f = 16'h0721;
         7'd39: f = 16'h072D;  7'd40: f = 16'h0739;  7'd41: f = 16'h0744;
         7'd42: f = 16'h074F;  7'd43: f = 16'h0759;  7'd44: f = 16'h0762;
         7'd45: f = 16'h076B;  7'd46: f = 16'h0773;  7'd47: f = 16'h077B;
         7'd48: f = 16'h0783;  7'd49: f = 16'h078A;  7'd50: f = 16'h0790;
         7'd51: f = 16'h0797;  7'd52: f = 16'h079D;  7'd53: f = 16'h07A2;
         7'd54: f = 16'h07A7;  7'd55: f = 16'h07AC;  7'd56: f = 16'h07B1;
         7'd57: f = 16'h07B6;  7'd58: f = 16'h07BA;  7'd59: f = 16'h07BE;
         7'd60: f = 16'h07C1;  7'd61: f = 16'h07C5;  7'd62: f = 16'h07C8;
         7'd63: f = 16'h07CB;  7'd64: f = 16'h07CE;  7'd65: f = 16'h07D1;
         7'd66: f = 16'h07D4;  7'd67: f = 16'h07D6;  7'd68: f = 16'h07D9;
         7'd69: f = 16'h07DB;  7'd70: f = 16'h07DD;  7'd71: f = 16'h07DF;
         default: f = 16'h07DF;
      endcase
      return f;
   endfunction

endpackage

[hdl/nva_note_rom.sv]
// ----------------------------------------------------------------------------
// nva_note_rom
// Note table lookup with the index clamped to the last usable note.
// ----------------------------------------------------------------------------
module nva_note_rom #(
   parameter int NOTE_COUNT = nva_pkg::NOTE_COUNT_DEFAULT
) (
   input  logic [7:0]  note_index,
   output logic [15:0] note_freq_out
);
   import nva_pkg::*;

   localparam int TopIdx = (NOTE_COUNT - 1 < TABLE_LAST) ? NOTE_COUNT - 1 : TABLE_LAST;
   localparam logic [7:0] TOP_INDEX = 8'(TopIdx);

   logic [7:0] clamped;

   assign clamped       = (note_index > TOP_INDEX) ? TOP_INDEX : note_index;
   assign note_freq_out = note_freq(clamped[6:0]);

endmodule

[hdl/nva_effect_core.sv]
// ----------------------------------------------------------------------------
// nva_effect_core
// Channel effect state and the per-item update: note start, vibrato sweep,
// arpeggio stepping, phrase end and silence.
// ----------------------------------------------------------------------------
module nva_effect_core #(
   parameter int NOTE_COUNT = nva_pkg::NOTE_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  nva_pkg::nva_req_type item,
   output nva_pkg::nva_rsp_type result
);
   import nva_pkg::*;

   logic [1:0]  effect_mode_ff,       effect_mode_in;
   logic [7:0]  vibrato_setting_ff,   vibrato_setting_in;
   logic [7:0]  tick_count_ff,        tick_count_in;
   logic [15:0] current_frequency_ff, current_frequency_in;
   logic [6:0]  base_note_ff,         base_note_in;
   logic [3:0]  arp_second_step_ff,   arp_second_step_in;
   logic [3:0]  arp_third_step_ff,    arp_third_step_in;

   logic [7:0]  tick_dec;
   logic [7:0]  tick_inc;
   logic [7:0]  arp_tick;
   logic [7:0]  arp_index;
   logic [7:0]  lookup_index;
   logic [15:0] lookup_freq;
   logic [15:0] vib_step;
   logic [15:0] vib_freq;
   logic [3:0]  kind;
   logic [7:0]  cmd_low;
   logic        note_start;

   assign tick_dec = tick_count_ff - 8'd1;
   assign tick_inc = tick_count_ff + 8'd1;
   assign arp_tick = (tick_inc == 8'd3) ? 8'd0 : tick_inc;

   always_comb begin
      if (arp_tick == 8'd0) begin
         arp_index = {1'b0, base_note_ff};
      end else if (arp_tick == 8'd1) begin
         arp_index = {1'b0, base_note_ff} + {4'd0, arp_second_step_ff};
      end else begin
         arp_index = {1'b0, base_note_ff} + {4'd0, arp_second_step_ff}
                   + {4'd0, arp_third_step_ff};
      end
   end

   assign lookup_index = (item.op == OP_ROW) ? {1'b0, item.row_note} : arp_index;

   nva_note_rom #(
      .NOTE_COUNT (NOTE_COUNT)
   ) u_rom (
      .note_index    (lookup_index),
      .note_freq_out (lookup_freq)
   );

   assign vib_step   = {12'd0, vibrato_setting_ff[3:0]};
   assign vib_freq   = (effect_mode_ff == MODE_VIB_UP) ? current_frequency_ff + vib_step
                                                       : current_frequency_ff - vib_step;
   assign kind       = item.row_command[15:12];
   assign cmd_low    = item.row_command[7:0];
   assign note_start = (item.row_note != 7'd0) && item.channel_owner;

   always_comb begin
      effect_mode_in       = effect_mode_ff;
      vibrato_setting_in   = vibrato_setting_ff;
      tick_count_in        = tick_count_ff;
      current_frequency_in = current_frequency_ff;
      base_note_in         = base_note_ff;
      arp_second_step_in   = arp_second_step_ff;
      arp_third_step_in    = arp_third_step_ff;
      result               = '0;

      case (item.op)
         OP_TICK: begin
            if (effect_mode_ff == MODE_VIB_UP || effect_mode_ff == MODE_VIB_DOWN) begin
               if (tick_dec == 8'd0) begin
                  // end of half period: reload and turn around
                  tick_count_in  = {4'd0, vibrato_setting_ff[7:4]};
                  effect_mode_in = (effect_mode_ff == MODE_VIB_UP) ? MODE_VIB_DOWN
                                                                   : MODE_VIB_UP;
               end else begin
                  tick_count_in        = tick_dec;
                  current_frequency_in = vib_freq;
                  result.freq_write    = 1'b1;
                  result.freq_low      = vib_freq[7:0];
                  result.freq_high     = vib_freq[15:8];
               end
            end else if (effect_mode_ff == MODE_ARP) begin
               tick_count_in     = arp_tick;
               result.freq_write = 1'b1;
               result.freq_low   = lookup_freq[7:0];
               result.freq_high  = lookup_freq[15:8];
            end
         end
         OP_ROW: begin
            if (note_start) begin
               if (item.is_noise) begin
                  result.noise_trigger = 1'b1;
               end else begin
                  result.freq_write    = 1'b1;
                  result.freq_low      = lookup_freq[7:0];
                  result.freq_high     = TRIGGER_BIT | lookup_freq[15:8];
                  current_frequency_in = lookup_freq;
               end
               effect_mode_in = MODE_NONE;
               base_note_in   = item.row_note;
            end
            if (kind == KIND_VIBRATO && item.channel_owner) begin
               effect_mode_in     = MODE_VIB_UP;
               vibrato_setting_in = cmd_low;
               tick_count_in      = {5'd0, cmd_low[7:5]};
            end else if (kind == KIND_ARPEGGIO && item.channel_owner) begin
               effect_mode_in     = MODE_ARP;
               arp_second_step_in = cmd_low[7:4];
               arp_third_step_in  = cmd_low[3:0];
               tick_count_in      = 8'd0;
            end else if (kind == KIND_END) begin
               result.end_phrase = 1'b1;
            end
         end
         OP_SILENCE: begin
            effect_mode_in = MODE_NONE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         effect_mode_ff       <= MODE_NONE;
         vibrato_setting_ff   <= '0;
         tick_count_ff        <= '0;
         current_frequency_ff <= '0;
         base_note_ff         <= '0;
         arp_second_step_ff   <= '0;
         arp_third_step_ff    <= '0;
      end else if (advance) begin
         effect_mode_ff       <= effect_mode_in;
         vibrato_setting_ff   <= vibrato_setting_in;
         tick_count_ff        <= tick_count_in;
         current_frequency_ff <= current_frequency_in;
         base_note_ff         <= base_note_in;
         arp_second_step_ff   <= arp_second_step_in;
         arp_third_step_ff    <= arp_third_step_in;
      end
   end

endmodule

[hdl/note_vibrato_arpeggio_engine_top.sv]
// ----------------------------------------------------------------------------
// note_vibrato_arpeggio_engine_top
// Tone effect engine for one channel: request register, effect core with
// the note table, and a response register.
// ----------------------------------------------------------------------------
// A request is held in the request register, then its result goes to the
//   response register; the effect state updates in that same step.
// Throughput: 1 request per cycle while responses are taken.
// A request is taken while a response waits, as long as the request stage
//   is free or moving.
// Reset: synchronous, clears both stage valids and all effect state.
module note_vibrato_arpeggio_engine_top #(
   parameter int NOTE_COUNT = nva_pkg::NOTE_COUNT_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  nva_pkg::nva_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nva_pkg::nva_rsp_type rsp_data
);
   import nva_pkg::*;

   nva_req_type req_ff;
   logic        req_valid_ff, req_valid_in;
   nva_rsp_type rsp_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   nva_rsp_type core_result;
   logic        advance;
   logic        req_fire;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign req_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   nva_effect_core #(
      .NOTE_COUNT (NOTE_COUNT)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (req_ff),
      .result  (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hdl/nva_checker.sv]
// ----------------------------------------------------------------------------
// nva_checker
// Port-level checks on the tone effect engine, bound to the top level.
// ----------------------------------------------------------------------------
module nva_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input nva_pkg::nva_rsp_type rsp_data
);
   import nva_pkg::*;

   logic [1:0] in_flight_ff, in_flight_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire     = req_valid && req_ready;
   assign rsp_fire     = rsp_valid && rsp_ready;
   assign in_flight_in = in_flight_ff + {1'b0, req_fire} - {1'b0, rsp_fire};

   // count requests taken but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= 2'd0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   // no response straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_quiet_freq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.freq_write |->
         rsp_data.freq_low == 8'd0 && rsp_data.freq_high == 8'd0)
      else $error("frequency bytes set without a write");

   a_noise_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.noise_trigger |-> !rsp_data.freq_write)
      else $error("noise trigger together with a frequency write");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> in_flight_ff != 2'd0)
      else $error("response without an outstanding request");

endmodule

bind note_vibrato_arpeggio_engine_top nva_checker u_nva_checker (.*);

[test/tb_note_vibrato_arpeggio_engine_top.sv]
// ----------------------------------------------------------------------------
// tb_note_vibrato_arpeggio_engine_top
// Drives rows, frame ticks and silence into the tone effect engine with random
// idle gaps and back-pressure, predicts every response from its own copy of
// the effect state and compares each response field by field.
// ----------------------------------------------------------------------------
module tb_note_vibrato_arpeggio_engine_top;
   timeunit 1ns;
   timeprecision 1ps;

   import nva_pkg::*;

   localparam int          NOTE_COUNT  = NOTE_COUNT_DEFAULT;
   localparam int          RANDOM_REQS = 800;
   localparam logic [1:0]  OP_UNUSED   = 2'd3;

   localparam logic [15:0] FREQ_TABLE [72] = '{
      16'h002C, 16'h009D, 16'h0107, 16'h016B, 16'h01C9, 16'h0223, 16'h0277, 16'h02C7,
      16'h0312, 16'h0358, 16'h039B, 16'h03DA, 16'h0416, 16'h044E, 16'h0483, 16'h04B5,
      16'h04E5, 16'h0511, 16'h053B, 16'h0563, 16'h0589, 16'h05AC, 16'h05CE, 16'h05ED,
      16'h060B, 16'h0627, 16'h0642, 16'h065B, 16'h0672, 16'h0689, 16'h069E, 16'h06B2,
      16'h06C4, 16'h06D6, 16'h06E7, 16'h06F7, 16'h0706, 16'h0714, 16'h0721, 16'h072D,
      16'h0739, 16'h0744, 16'h074F, 16'h0759, 16'h0762, 16'h076B, 16'h0773, 16'h077B,
      16'h0783, 16'h078A, 16'h0790, 16'h0797, 16'h079D, 16'h07A2, 16'h07A7, 16'h07AC,
      16'h07B1, 16'h07B6, 16'h07BA, 16'h07BE, 16'h07C1, 16'h07C5, 16'h07C8, 16'h07CB,
      16'h07CE, 16'h07D1, 16'h07D4, 16'h07D6, 16'h07D9, 16'h07DB, 16'h07DD, 16'h07DF
   };

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   nva_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   nva_rsp_type rsp_data;

   note_vibrato_arpeggio_engine_top #(
      .NOTE_COUNT(NOTE_COUNT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted effect state
   logic [1:0]  fx_mode;
   logic [7:0]  vib_setting;
   logic [7:0]  fx_ticks;
   logic [15:0] cur_freq;
   logic [6:0]  base_note;
   logic [3:0]  arp_step2;
   logic [3:0]  arp_step3;

   nva_req_type request_q[$];
   nva_rsp_type predicted_rsp_q[$];
   int          request_total;
   int          accepted_count = 0;
   int          error_count    = 0;
   logic        hold_rsp       = 1'b0;

   int          req_gap_left   = 0;
   int          req_burst_left = 0;
   int          rsp_stall_left = 0;
   int          rsp_burst_left = 0;

   function automatic logic [15:0] note_lookup(input int idx);
      int top;
      top = (NOTE_COUNT - 1 < 71) ? NOTE_COUNT - 1 : 71;
      if (idx > top) idx = top;
      return FREQ_TABLE[idx];
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Advance the predicted state by one request and return its response.
   function automatic nva_rsp_type advance_effect(input nva_req_type r);
      nva_rsp_type res;
      logic [15:0] f;
      logic [3:0]  kind;
      logic [7:0]  param;
      int          idx;
      res = '0;
      case (r.op)
         OP_TICK: begin
            if (fx_mode == MODE_VIB_UP || fx_mode == MODE_VIB_DOWN) begin
               fx_ticks = fx_ticks - 8'd1;
               if (fx_ticks == 8'd0) begin
                  fx_ticks = {4'h0, vib_setting[7:4]};
                  fx_mode  = (fx_mode == MODE_VIB_UP) ? MODE_VIB_DOWN : MODE_VIB_UP;
               end else begin
                  if (fx_mode == MODE_VIB_UP) cur_freq = cur_freq + {12'h0, vib_setting[3:0]};
                  else cur_freq = cur_freq - {12'h0, vib_setting[3:0]};
                  res.freq_write = 1'b1;
                  res.freq_low   = cur_freq[7:0];
                  res.freq_high  = cur_freq[15:8];
               end
            end else if (fx_mode == MODE_ARP) begin
               fx_ticks = fx_ticks + 8'd1;
               if (fx_ticks == 8'd3) fx_ticks = 8'd0;
               idx = base_note;
               if (fx_ticks == 8'd1) idx = idx + arp_step2;
               else if (fx_ticks != 8'd0) idx = idx + arp_step2 + arp_step3;
               f = note_lookup(idx);
               res.freq_write = 1'b1;
               res.freq_low   = f[7:0];
               res.freq_high  = f[15:8];
            end
         end
         OP_ROW: begin
            kind  = r.row_command[15:12];
            param = r.row_command[7:0];
            if (r.row_note != 7'd0 && r.channel_owner) begin
               if (r.is_noise) begin
                  res.noise_trigger = 1'b1;
               end else begin
                  f = note_lookup(r.row_note);
                  res.freq_write = 1'b1;
                  res.freq_low   = f[7:0];
                  res.freq_high  = TRIGGER_BIT | f[15:8];
                  cur_freq       = f;
               end
               fx_mode   = MODE_NONE;
               base_note = r.row_note;
            end
            if (kind == KIND_VIBRATO && r.channel_owner) begin
               fx_mode     = MODE_VIB_UP;
               vib_setting = param;
               fx_ticks    = {5'd0, param[7:5]};
            end else if (kind == KIND_ARPEGGIO && r.channel_owner) begin
               fx_mode   = MODE_ARP;
               arp_step2 = param[7:4];
               arp_step3 = param[3:0];
               fx_ticks  = 8'd0;
            end else if (kind == KIND_END) begin
               res.end_phrase = 1'b1;
            end
         end
         OP_SILENCE: fx_mode = MODE_NONE;
         default: ;
      endcase
      return res;
   endfunction

   // request driver and predictor
   always @(posedge clock) begin
      if (reset) begin
         req_valid    <= 1'b0;
         req_gap_left = 0;
         fx_mode      = MODE_NONE;
         vib_setting  = '0;
         fx_ticks     = '0;
         cur_freq     = '0;
         base_note    = '0;
         arp_step2    = '0;
         arp_step3    = '0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_rsp_q.push_back(advance_effect(req_data));
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
               req_data  <= request_q.pop_front();
               req_valid <= 1'b1;
               if (req_burst_left > 0) begin
                  req_burst_left--;
               end else begin
                  req_gap_left = idle_len();
                  if ($urandom_range(0, 49) == 0) req_burst_left = $urandom_range(20, 80);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and ready generator
   always @(posedge clock) begin
      nva_rsp_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp_q.size() == 0) begin
               $error("unexpected response %h", rsp_data);
               error_count++;
            end else begin
               exp_rsp = predicted_rsp_q.pop_front();
               if (rsp_data.freq_write !== exp_rsp.freq_write) begin
                  $error("freq_write expected %0h got %0h", exp_rsp.freq_write,
                         rsp_data.freq_write);
                  error_count++;
               end
               if (rsp_data.freq_low !== exp_rsp.freq_low) begin
                  $error("freq_low expected %0h got %0h", exp_rsp.freq_low,
                         rsp_data.freq_low);
                  error_count++;
               end
               if (rsp_data.freq_high !== exp_rsp.freq_high) begin
                  $error("freq_high expected %0h got %0h", exp_rsp.freq_high,
                         rsp_data.freq_high);
                  error_count++;
               end
               if (rsp_data.noise_trigger !== exp_rsp.noise_trigger) begin
                  $error("noise_trigger expected %0h got %0h", exp_rsp.noise_trigger,
                         rsp_data.noise_trigger);
                  error_count++;
               end
               if (rsp_data.end_phrase !== exp_rsp.end_phrase) begin
                  $error("end_phrase expected %0h got %0h", exp_rsp.end_phrase,
                         rsp_data.end_phrase);
                  error_count++;
               end
            end
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ready <= 1'b0;
         end else if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_burst_left > 0) begin
               rsp_burst_left--;
            end else begin
               rsp_stall_left = idle_len();
               if ($urandom_range(0, 49) == 0) rsp_burst_left = $urandom_range(20, 80);
            end
         end
      end
   end

   // hold off responses for a long stretch so the engine backs up
   initial begin
      wait (accepted_count >= 300);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (200) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic queue_request(input logic [1:0] op, input logic [6:0] note,
                                input logic [15:0] cmd, input logic noise,
                                input logic owner);
      nva_req_type r;
      r.op            = op;
      r.row_note      = note;
      r.row_command   = cmd;
      r.is_noise      = noise;
      r.channel_owner = owner;
      request_q.push_back(r);
   endtask

   initial begin
      int          pick;
      int          n_ticks;
      logic [6:0]  note;
      logic [7:0]  param;
      logic [15:0] cmd;

      // vibrato from zero frequency: flip down at once, then wrap below zero
      queue_request(OP_ROW, 7'd0, {KIND_VIBRATO, 12'h03F}, 1'b0, 1'b1);
      repeat (3) queue_request(OP_TICK, 7'd0, 16'h0000, 1'b0, 1'b0);
      // arpeggio on the reset base note, widest steps
      queue_request(OP_ROW, 7'd0, {KIND_ARPEGGIO, 12'h0FF}, 1'b0, 1'b1);
      repeat (3) queue_request(OP_TICK, 7'h7F, 16'hFFFF, 1'b1, 1'b1);
      queue_request(OP_ROW, 7'd1, 16'h0000, 1'b0, 1'b1);
      queue_request(OP_ROW, 7'd71, {KIND_END, 12'h000}, 1'b1, 1'b1);
      // note past the table end together with the longest vibrato setting
      queue_request(OP_ROW, 7'd127, {KIND_VIBRATO, 12'hFFF}, 1'b0, 1'b1);
      queue_request(OP_TICK, 7'd0, 16'h0000, 1'b0, 1'b0);
      // rows for a channel the layer does not own
      queue_request(OP_ROW, 7'd72, {KIND_END, 12'h0FF}, 1'b0, 1'b0);
      queue_request(OP_ROW, 7'd5, {KIND_VIBRATO, 12'h012}, 1'b0, 1'b0);
      queue_request(OP_ROW, 7'd5, {KIND_ARPEGGIO, 12'h0FF}, 1'b1, 1'b0);
      queue_request(OP_TICK, 7'd0, 16'h0000, 1'b0, 1'b0);
      queue_request(OP_SILENCE, 7'd0, 16'h0000, 1'b0, 1'b0);
      queue_request(OP_TICK, 7'd0, 16'h0000, 1'b0, 1'b0);
      queue_request(OP_UNUSED, 7'h7F, 16'hFFFF, 1'b1, 1'b1);
      // arpeggio indexes that saturate at the last note
      queue_request(OP_ROW, 7'd100, {KIND_ARPEGGIO, 12'hFFF}, 1'b0, 1'b1);
      repeat (2) queue_request(OP_TICK, 7'd0, 16'h0000, 1'b0, 1'b0);
      // period zero: first tick wraps the count instead of flipping
      queue_request(OP_ROW, 7'd64, {KIND_VIBRATO, 12'h000}, 1'b0, 1'b1);
      queue_request(OP_TICK, 7'd0, 16'h0000, 1'b0, 1'b0);
      queue_request(OP_ROW, 7'd0, 16'h0000, 1'b0, 1'b0);
      queue_request(OP_ROW, 7'd10, 16'h5AAA, 1'b0, 1'b1);

      while (request_q.size() < RANDOM_REQS + 25) begin
         if ($urandom_range(0, 99) < 70) begin
            // a row that may set up an effect, followed by a run of ticks
            pick = $urandom_range(0, 9);
            if (pick == 0) note = 7'd0;
            else if (pick < 8) note = 7'($urandom_range(1, 71));
            else note = 7'($urandom_range(72, 127));
            param = 8'($urandom);
            pick  = $urandom_range(0, 9);
            if (pick < 4) begin
               if ($urandom_range(0, 1)) param[7:4] = 4'($urandom_range(1, 4));
               cmd = {KIND_VIBRATO, 4'($urandom), param};
            end else if (pick < 7) begin
               cmd = {KIND_ARPEGGIO, 4'($urandom), param};
            end else if (pick < 8) begin
               cmd = {KIND_END, 4'($urandom), param};
            end else begin
               cmd = 16'($urandom);
            end
            queue_request(OP_ROW, note, cmd, $urandom_range(0, 7) == 0,
                          $urandom_range(0, 9) != 0);
            n_ticks = $urandom_range(1, 24);
            repeat (n_ticks)
               queue_request(OP_TICK, 7'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
            if ($urandom_range(0, 5) == 0)
               queue_request(OP_SILENCE, 7'($urandom), 16'($urandom), 1'($urandom),
                             1'($urandom));
         end else begin
            queue_request(2'($urandom_range(0, 3)), 7'($urandom), 16'($urandom),
                          1'($urandom), 1'($urandom));
         end
      end
      request_total = request_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < request_total || predicted_rsp_q.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
